// ===== rtl/nlb_pkg.sv =====
package nlb_pkg;

    localparam int SAMPLE_W      = 32;
    localparam int LOG_W         = 16;
    localparam int FRAC_SHIFT    = 12;
    localparam int TERM_W        = 36;
    localparam int SUM_W         = 40;
    localparam int PROD_W        = TERM_W + LOG_W - FRAC_SHIFT;
    localparam int SCALE_SHIFT   = 6;
    localparam int HALVINGS      = 11;
    localparam int STEP_W        = $clog2(HALVINGS);
    localparam int MAX_TERMS_DEF = 64;

    localparam logic [TERM_W-1:0] ONE_Q16  = TERM_W'(65536);
    localparam logic [TERM_W-1:0] STOP_Q16 = TERM_W'(655);
    localparam logic [LOG_W-1:0]  TOP_Q12  = LOG_W'(61440);

    typedef enum logic [1:0] {
        EXP_IDLE,
        EXP_CHECK,
        EXP_DIV_GO,
        EXP_DIV_WAIT
    } exp_state_t;

    typedef enum logic [1:0] {
        BIS_IDLE,
        BIS_START,
        BIS_WAIT,
        BIS_DONE
    } bis_state_t;

endpackage

// ===== rtl/nlb_div.sv =====
module nlb_div #(
    parameter int DIVD_W = 40,
    parameter int DIV_W  = 7
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [DIVD_W-1:0] dividend,
    input  logic [DIV_W-1:0]  divisor,
    output logic              done,
    output logic [DIVD_W-1:0] quotient
);
    // restoring division, two quotient bits per cycle
    localparam int STEPS = (DIVD_W + 1) / 2;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DIVD_W-1:0] quo_reg, quo_next;
    logic [DIV_W-1:0]  rem_reg, rem_next;
    logic [DIV_W-1:0]  den_reg, den_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    always_comb begin
        logic [DIV_W:0]    r;
        logic [DIVD_W-1:0] q;
        logic [DIV_W-1:0]  rm;
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        q         = quo_reg;
        rm        = rem_reg;
        r         = '0;
        if (start && !busy_reg) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            den_next  = divisor;
        end else if (busy_reg) begin
            for (int i = 0; i < 2; i++) begin
                r = {rm, q[DIVD_W-1]};
                q = {q[DIVD_W-2:0], 1'b0};
                if (r >= {1'b0, den_reg}) begin
                    r    = r - {1'b0, den_reg};
                    q[0] = 1'b1;
                end
                rm = r[DIV_W-1:0];
            end
            quo_next = q;
            rem_next = rm;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/nlb_exp.sv =====
module nlb_exp #(
    parameter int MAX_TERMS = nlb_pkg::MAX_TERMS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [nlb_pkg::LOG_W-1:0]  mid,
    output logic                       done,
    output logic [nlb_pkg::SUM_W-1:0]  sum
);
    import nlb_pkg::*;

    localparam int K_W = $clog2(MAX_TERMS + 2);

    exp_state_t              state_reg, state_next;
    logic [LOG_W-1:0]        mid_reg, mid_next;
    logic [TERM_W-1:0]       term_reg, term_next;
    logic [SUM_W-1:0]        sum_reg, sum_next;
    logic [K_W-1:0]          k_reg, k_next;
    logic [PROD_W-1:0]       prod_reg, prod_next;
    logic [TERM_W+LOG_W-1:0] full_prod;
    logic                    done_next, done_reg;
    logic                    div_start, div_done;
    logic [PROD_W-1:0]       div_quot;

    assign full_prod = {{LOG_W{1'b0}}, term_reg} * {{TERM_W{1'b0}}, mid_reg};

    nlb_div #(
        .DIVD_W (PROD_W),
        .DIV_W  (K_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (k_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= EXP_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        mid_reg  <= mid_next;
        term_reg <= term_next;
        sum_reg  <= sum_next;
        k_reg    <= k_next;
        prod_reg <= prod_next;
    end

    always_comb begin
        state_next = state_reg;
        mid_next   = mid_reg;
        term_next  = term_reg;
        sum_next   = sum_reg;
        k_next     = k_reg;
        prod_next  = prod_reg;
        done_next  = 1'b0;
        div_start  = 1'b0;
        case (state_reg)
            EXP_IDLE: begin
                if (start) begin
                    mid_next   = mid;
                    term_next  = ONE_Q16;
                    sum_next   = '0;
                    k_next     = K_W'(1);
                    state_next = EXP_CHECK;
                end
            end
            EXP_CHECK: begin
                if (term_reg >= STOP_Q16 && k_reg <= K_W'(MAX_TERMS)) begin
                    sum_next   = sum_reg + SUM_W'(term_reg);
                    prod_next  = full_prod[TERM_W+LOG_W-1:FRAC_SHIFT];
                    state_next = EXP_DIV_GO;
                end else begin
                    done_next  = 1'b1;
                    state_next = EXP_IDLE;
                end
            end
            EXP_DIV_GO: begin
                div_start  = 1'b1;
                state_next = EXP_DIV_WAIT;
            end
            EXP_DIV_WAIT: begin
                if (div_done) begin
                    // quotient is the next term, bounded well inside the term width
                    term_next  = div_quot[TERM_W-1:0];
                    k_next     = k_reg + 1'b1;
                    state_next = EXP_CHECK;
                end
            end
            default: state_next = EXP_IDLE;
        endcase
    end

    assign done = done_reg;
    assign sum  = sum_reg;

endmodule

// ===== rtl/natural_log_bisection_unit.sv =====
// natural logarithm of an unsigned Q22.10 sample, result in unsigned Q4.12
//
// input channel s_*: one sample per transfer, s_tdata[31:0] = sample_value
// result channel m_*: one result per sample, m_tdata[15:0] = log_value
//
// the block bisects [0, 15] in 11 halvings; each halving evaluates e^mid as a
// truncated Taylor series on one shared multiplier and one shared divider
// that yields two quotient bits per cycle
// the term count grows with mid, from a handful near 0 to about 43 near 15
// s_tready is high only while no sample is in work; one item at a time
//
// the result sits in an output register until taken; if m_tready is low the
// next sample can still be taken and worked, and it waits at the end until
// the output register frees up
// reset (aresetn low, synchronous) drops any sample in work and any result
module natural_log_bisection_unit #(
    parameter int MAX_TERMS = nlb_pkg::MAX_TERMS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] sample_value
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [15:0] log_value
);
    import nlb_pkg::*;

    bis_state_t              state_reg, state_next;
    logic [SAMPLE_W-1:0]     sample_reg, sample_next;
    logic [LOG_W-1:0]        lo_reg, lo_next;
    logic [LOG_W-1:0]        hi_reg, hi_next;
    logic [LOG_W-1:0]        mid_reg, mid_next;
    logic [STEP_W-1:0]       step_reg, step_next;
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [LOG_W-1:0]        m_tdata_reg, m_tdata_next;
    logic [LOG_W:0]          bound_sum;
    logic [SUM_W-1:0]        scaled;
    logic                    exp_start, exp_done;
    logic [SUM_W-1:0]        exp_sum;

    assign bound_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    // Q22.10 brought up to Q22.16
    assign scaled    = {{(SUM_W - SAMPLE_W - SCALE_SHIFT){1'b0}}, sample_reg,
                        {SCALE_SHIFT{1'b0}}};

    // the series unit latches the new midpoint in the same cycle as mid_reg
    nlb_exp #(
        .MAX_TERMS (MAX_TERMS)
    ) u_exp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (exp_start),
        .mid     (bound_sum[LOG_W:1]),
        .done    (exp_done),
        .sum     (exp_sum)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= BIS_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        sample_reg  <= sample_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        mid_reg     <= mid_next;
        step_reg    <= step_next;
        m_tdata_reg <= m_tdata_next;
    end

    always_comb begin
        state_next    = state_reg;
        sample_next   = sample_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        mid_next      = mid_reg;
        step_next     = step_reg;
        m_tdata_next  = m_tdata_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        exp_start     = 1'b0;
        s_tready      = 1'b0;
        case (state_reg)
            BIS_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    sample_next = s_tdata;
                    lo_next     = '0;
                    hi_next     = TOP_Q12;
                    step_next   = '0;
                    state_next  = BIS_START;
                end
            end
            BIS_START: begin
                mid_next   = bound_sum[LOG_W:1];
                exp_start  = 1'b1;
                state_next = BIS_WAIT;
            end
            BIS_WAIT: begin
                if (exp_done) begin
                    if (scaled > exp_sum) begin
                        lo_next = mid_reg;
                    end else begin
                        hi_next = mid_reg;
                    end
                    if (step_reg == STEP_W'(HALVINGS - 1)) begin
                        state_next = BIS_DONE;
                    end else begin
                        step_next  = step_reg + 1'b1;
                        state_next = BIS_START;
                    end
                end
            end
            BIS_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tdata_next  = mid_reg;
                    m_tvalid_next = 1'b1;
                    state_next    = BIS_IDLE;
                end
            end
            default: state_next = BIS_IDLE;
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import nlb_pkg::*;

    localparam int SERIES_CAP   = MAX_TERMS_DEF;
    localparam int IDLE_PERCENT = 37;
    localparam int HOLD_CYCLES  = 30000;
    localparam int HOLD_AFTER   = 6;
    localparam int DRAIN_SETTLE = 50;
    localparam int RANDOM_ITEMS = 80;
    localparam longint LIMIT_CYCLES = 8_000_000;

    typedef struct {
        logic [SAMPLE_W-1:0] sample;
        bit                  drain_first;
    } sample_item_t;

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [SAMPLE_W-1:0] s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [LOG_W-1:0]    m_tdata;

    sample_item_t     pending_samples[$];
    logic [LOG_W-1:0] expected_logs[$];
    int               samples_sent;
    int               logs_checked;
    int               mismatches;
    int               hold_left;
    bit               hold_done;
    longint           cycle_count;
    bit               calm;

    natural_log_bisection_unit #(
        .MAX_TERMS(SERIES_CAP)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // no random idling on either side while this window of samples goes through
    assign calm = (samples_sent >= 60) && (samples_sent < 85);

    // e^x for x in Q4.12, Q22.16 truncated series
    function automatic logic [63:0] exp_q16(input logic [LOG_W-1:0] x);
        logic [63:0] term;
        logic [63:0] acc;
        int unsigned k;
        term = 64'(ONE_Q16);
        acc  = 64'd0;
        k    = 1;
        while (term >= 64'(STOP_Q16) && k <= SERIES_CAP) begin
            acc  = acc + term;
            term = ((term * 64'(x)) >> FRAC_SHIFT) / 64'(k);
            k++;
        end
        return acc;
    endfunction

    function automatic logic [LOG_W-1:0] log_of_sample(input logic [SAMPLE_W-1:0] sample);
        logic [63:0] scaled;
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        scaled = 64'(sample) << SCALE_SHIFT;
        lo     = 0;
        hi     = TOP_Q12;
        mid    = 0;
        for (int i = 0; i < HALVINGS; i++) begin
            mid = (lo + hi) >> 1;
            if (scaled > exp_q16(LOG_W'(mid))) begin
                lo = mid;
            end else begin
                hi = mid;
            end
        end
        return LOG_W'(mid);
    endfunction

    function automatic logic [SAMPLE_W-1:0] near_threshold(input int unsigned mid,
                                                           input int offset);
        logic [63:0] edge_val;
        edge_val = (exp_q16(LOG_W'(mid)) >> SCALE_SHIFT) + 64'(signed'(offset));
        return SAMPLE_W'(edge_val);
    endfunction

    task automatic queue_sample(input logic [SAMPLE_W-1:0] sample, input bit drain_first);
        sample_item_t item;
        item.sample      = sample;
        item.drain_first = drain_first;
        pending_samples.push_back(item);
    endtask

    // sender: holds tvalid until the transfer, idles only between transfers
    always @(posedge aclk) begin
        bit offer;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end else begin
            offer = 1'b0;
            if (s_tvalid && s_tready) begin
                expected_logs.push_back(log_of_sample(s_tdata));
                void'(pending_samples.pop_front());
                samples_sent++;
            end
            if (s_tvalid && !s_tready) begin
                offer = 1'b1;
            end else if (pending_samples.size() != 0) begin
                if (pending_samples[0].drain_first && expected_logs.size() != 0) begin
                    offer = 1'b0;
                end else begin
                    offer = calm || ($urandom_range(99) >= IDLE_PERCENT);
                end
            end
            s_tvalid <= offer;
            if (offer) begin
                s_tdata <= pending_samples[0].sample;
            end
        end
    end

    // receiver: random stalls plus one long hold-off so the block backs up
    always @(posedge aclk) begin
        logic [LOG_W-1:0] want;
        bit ready;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_logs.size() == 0) begin
                    $display("%0t: unexpected result, expected none actual log_value %0d",
                             $time, m_tdata);
                    mismatches++;
                end else begin
                    want = expected_logs.pop_front();
                    if (m_tdata !== want) begin
                        $display("%0t: log_value mismatch, expected %0d actual %0d",
                                 $time, want, m_tdata);
                        mismatches++;
                    end
                end
                logs_checked++;
            end
            if (hold_left > 0) begin
                hold_left--;
                ready = 1'b0;
            end else if (!hold_done && logs_checked == HOLD_AFTER) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                ready     = 1'b0;
            end else begin
                ready = calm || ($urandom_range(99) >= IDLE_PERCENT);
            end
            m_tready <= ready;
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        int kind;
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        m_tready     = 1'b0;
        samples_sent = 0;
        logs_checked = 0;
        mismatches   = 0;
        hold_left    = 0;
        hold_done    = 1'b0;
        cycle_count  = 0;

        // zero, near one, two, near e, threshold edges up to e^15, full scale, bit patterns
        queue_sample(32'd0, 1'b0);
        queue_sample(32'd1, 1'b0);
        queue_sample(32'd1023, 1'b0);
        queue_sample(32'd1024, 1'b0);
        queue_sample(32'd1025, 1'b0);
        queue_sample(32'd2048, 1'b0);
        queue_sample(32'd2783, 1'b0);
        queue_sample(32'd2784, 1'b0);
        queue_sample(near_threshold(30, 0), 1'b0);
        queue_sample(near_threshold(30, 1), 1'b0);
        queue_sample(near_threshold(61410, 0), 1'b0);
        queue_sample(near_threshold(61410, 1), 1'b0);
        queue_sample(near_threshold(30720, 0), 1'b0);
        queue_sample(near_threshold(30720, 1), 1'b0);
        queue_sample(32'hFFFF_FFFF, 1'b0);
        queue_sample(32'h8000_0000, 1'b0);
        queue_sample(32'h7FFF_FFFF, 1'b0);
        queue_sample(32'hAAAA_AAAA, 1'b0);
        queue_sample(32'h5555_5555, 1'b0);
        queue_sample(32'h0001_0000, 1'b0);
        queue_sample(32'h0000_0400 << 20, 1'b0);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            kind = $urandom_range(9);
            case (kind)
                0, 1, 2: begin
                    queue_sample($urandom, i == 0 || i == 40);
                end
                3, 4: begin
                    queue_sample($urandom >> $urandom_range(31), i == 0 || i == 40);
                end
                5: begin
                    queue_sample($urandom_range(2048), i == 0 || i == 40);
                end
                6, 7, 8: begin
                    queue_sample(near_threshold(30 * $urandom_range(1, 2047),
                                                int'($urandom_range(4)) - 2),
                                 i == 0 || i == 40);
                end
                default: begin
                    if ($urandom_range(1)) begin
                        queue_sample(32'hFFFF_FFFF - $urandom_range(15), i == 0 || i == 40);
                    end else begin
                        queue_sample($urandom_range(3), i == 0 || i == 40);
                    end
                end
            endcase
        end

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_samples.size() != 0 || s_tvalid || expected_logs.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_SETTLE) @(posedge aclk);

        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
